// ----- rtl/tksd_pkg.sv -----
// Package with shared types and constants of the terminal key sequence decoder.
package tksd_pkg;

   localparam int KEY_SLOTS = 8;
   localparam int SLOT_W = $clog2(KEY_SLOTS) > 0 ? $clog2(KEY_SLOTS) : 1;

   localparam logic [1:0] KIND_PRESS     = 2'd0;
   localparam logic [1:0] KIND_FOCUS_IN  = 2'd1;
   localparam logic [1:0] KIND_FOCUS_OUT = 2'd2;

   localparam logic [8:0] NO_KEY      = 9'd0;
   localparam logic [8:0] KEY_ESC     = 9'd256;
   localparam logic [8:0] ENTER_KEY   = 9'd257;
   localparam logic [8:0] SPACE_KEY   = 9'd258;
   localparam logic [8:0] KEY_UP      = 9'd259;
   localparam logic [8:0] DOWN_ARROW  = 9'd260;
   localparam logic [8:0] LEFT_ARROW  = 9'd261;
   localparam logic [8:0] RIGHT_ARROW = 9'd262;
   localparam logic [8:0] CTRL_C_KEY  = 9'd263;
   localparam logic [8:0] CTRL_L_KEY  = 9'd264;
   localparam logic [8:0] KEY_LOWER_O = 9'd111;

   localparam logic [1:0] TYPE_PRESS   = 2'd1;
   localparam logic [1:0] TYPE_REPEAT  = 2'd2;
   localparam logic [1:0] TYPE_RELEASE = 2'd3;

   localparam logic [1:0] REG_KITTY       = 2'd0;
   localparam logic [1:0] REG_ESC_ALONE   = 2'd1;
   localparam logic [1:0] REG_HOLD_FIRST  = 2'd2;
   localparam logic [1:0] REG_HOLD_REPEAT = 2'd3;

   typedef struct packed {
      logic        func;
      logic [7:0]  data_byte;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [8:0] key;
      logic       repeat_res;
      logic       last;
   } rsp_type;

endpackage

// ----- rtl/terminal_key_sequence_decoder.sv -----
// Top level of the terminal key sequence decoder: parser, key-slot table and result buffer.
// The block takes one transfer at a time and stalls its input until that transfer is done.
// A transfer that causes no result goes through decode and a timeout check, then back to idle.
// Each key press is handled by one shared compare unit, which scans the key-slot table one slot
// per cycle before the slot is updated; a press caused by a timed-out sequence is followed by a
// second timeout check.
// A transfer causes at most two results, sent one after the other and held while the receiver
// stalls. Results are buffered and drained before the next transfer is taken.
// Configuration registers lie at byte addresses 0, 4, 8 and 12.
module terminal_key_sequence_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tksd_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tksd_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_ESC  = 3'd1;
   localparam logic [2:0] PH_SS3  = 3'd2;
   localparam logic [2:0] PH_CSTA = 3'd3;
   localparam logic [2:0] PH_CBOD = 3'd4;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_APPLY = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam int SLOT_CNT_W = tksd_pkg::SLOT_W;
   localparam logic [SLOT_CNT_W-1:0] SLOT_LAST = SLOT_CNT_W'(tksd_pkg::KEY_SLOTS - 1);

   // configuration
   logic        kitty_ff;
   logic [15:0] esc_alone_ff, hold_first_ff, hold_repeat_ff;

   // parser state
   logic [2:0]  phase_ff, phase_in;
   logic        priv_ff, priv_in;
   logic [2:0]  pidx_ff, pidx_in;
   logic [1:0]  sidx_ff, sidx_in;
   logic [16:0] kc_ff, kc_in, md_ff, md_in, et_ff, et_in;
   logic [31:0] since_ff, since_in;

   // slot table
   logic [8:0]  slot_key_ff  [tksd_pkg::KEY_SLOTS];
   logic        slot_down_ff [tksd_pkg::KEY_SLOTS];
   logic [31:0] slot_ms_ff   [tksd_pkg::KEY_SLOTS];

   // sequencer
   logic [2:0]  st_ff;
   tksd_pkg::req_type item_ff;
   logic [8:0]  pk_key_ff [2];
   logic [1:0]  pk_type_ff [2];
   logic [1:0]  npress_ff;
   logic        pcur_ff;
   logic [SLOT_CNT_W-1:0] scan_ff;
   logic        found_ff, hasfree_ff;
   logic [SLOT_CNT_W-1:0] fidx_ff, freeidx_ff;
   tksd_pkg::rsp_type obuf_ff [2];
   logic [1:0]  ocnt_ff;
   logic        orp_ff;

   assign pready = 1'b1;
   assign req_stall = (st_ff != ST_IDLE);

   always_comb begin
      unique case (paddr[3:2])
         tksd_pkg::REG_KITTY:      prdata = {31'd0, kitty_ff};
         tksd_pkg::REG_ESC_ALONE:  prdata = {16'd0, esc_alone_ff};
         tksd_pkg::REG_HOLD_FIRST: prdata = {16'd0, hold_first_ff};
         default:                  prdata = {16'd0, hold_repeat_ff};
      endcase
   end

   function automatic logic [16:0] add_digit(input logic [16:0] p, input logic [3:0] d);
      logic [20:0] v;
      v = (p[16] ? {5'd0, p[15:0]} : 21'd0) * 21'd10 + {17'd0, d};
      if (v > 21'd65535) v = 21'd65535;
      return {1'b1, v[15:0]};
   endfunction

   function automatic logic [8:0] plain_key(input logic [7:0] c);
      if (c == 8'd3) return tksd_pkg::CTRL_C_KEY;
      if (c == 8'd12) return tksd_pkg::CTRL_L_KEY;
      if (c == 8'd13 || c == 8'd10) return tksd_pkg::ENTER_KEY;
      if (c == 8'd32) return tksd_pkg::SPACE_KEY;
      if (c >= 8'h41 && c <= 8'h5A) return {1'b0, c + 8'd32};
      if (c >= 8'h80 || c < 8'd32) return tksd_pkg::NO_KEY;
      return {1'b0, c};
   endfunction

   // Decode of one transfer: parser next state plus up to two presses or a focus event.
   logic [8:0] dk [2];
   logic [1:0] dt [2];
   logic [1:0] dn;
   logic       dfocus, dclear;
   logic [1:0] dkind;
   logic [15:0] mods, etv;
   logic [1:0] ctype;
   logic [8:0] ckey;
   logic [7:0] b;
   logic [15:0] code;

   always_comb begin
      b = item_ff.data_byte;
      phase_in = phase_ff; priv_in = priv_ff; pidx_in = pidx_ff; sidx_in = sidx_ff;
      kc_in = kc_ff; md_in = md_ff; et_in = et_ff; since_in = since_ff;
      dk[0] = tksd_pkg::NO_KEY; dk[1] = tksd_pkg::NO_KEY;
      dt[0] = tksd_pkg::TYPE_PRESS; dt[1] = tksd_pkg::TYPE_PRESS;
      dn = 2'd0; dfocus = 1'b0; dclear = 1'b0; dkind = tksd_pkg::KIND_FOCUS_IN;
      mods = (md_ff[16] && md_ff[15:0] >= 16'd1) ? md_ff[15:0] - 16'd1 : 16'd0;
      etv = (et_ff[16] && et_ff[15:0] >= 16'd1) ? et_ff[15:0] : 16'd1;
      ctype = (etv == 16'd2) ? tksd_pkg::TYPE_REPEAT :
              (etv == 16'd3) ? tksd_pkg::TYPE_RELEASE : tksd_pkg::TYPE_PRESS;
      code = kc_ff[15:0];
      ckey = tksd_pkg::NO_KEY;
      if (b == 8'h41) ckey = tksd_pkg::KEY_UP;
      else if (b == 8'h42) ckey = tksd_pkg::DOWN_ARROW;
      else if (b == 8'h43) ckey = tksd_pkg::RIGHT_ARROW;
      else if (b == 8'h44) ckey = tksd_pkg::LEFT_ARROW;
      else if (b == 8'h75 && kc_ff[16]) begin
         if (code == 16'd27) ckey = tksd_pkg::KEY_ESC;
         else if (code == 16'd13) ckey = tksd_pkg::ENTER_KEY;
         else if (code == 16'd32) ckey = tksd_pkg::SPACE_KEY;
         else if (code == 16'h63 && mods[2]) ckey = tksd_pkg::CTRL_C_KEY;
         else if (code == 16'h6C && mods[2]) ckey = tksd_pkg::CTRL_L_KEY;
         else if (code >= 16'h41 && code <= 16'h5A) ckey = code[8:0] + 9'd32;
         else if (code > 16'd32 && code < 16'd127) ckey = code[8:0];
      end
      if (!item_ff.func) begin
         unique case (phase_ff)
            PH_ESC: begin
               if (b == 8'h4F) phase_in = PH_SS3;
               else if (b == 8'h5B) begin
                  phase_in = PH_CSTA; priv_in = 1'b0; pidx_in = 3'd0; sidx_in = 2'd0;
                  kc_in = 17'd0; md_in = 17'd0; et_in = 17'd0;
               end else begin
                  dk[0] = tksd_pkg::KEY_ESC; dn = 2'd1;
                  phase_in = PH_IDLE;
                  if (b == 8'h1B) begin
                     phase_in = PH_ESC; since_in = item_ff.now_ms;
                  end else if (plain_key(b) != tksd_pkg::NO_KEY) begin
                     dk[1] = plain_key(b); dn = 2'd2;
                  end
               end
            end
            PH_SS3: begin
               phase_in = PH_IDLE;
               if (b >= 8'h41 && b <= 8'h44) begin
                  dk[0] = ckey; dn = 2'd1;
               end
            end
            PH_CSTA, PH_CBOD: begin
               phase_in = PH_CBOD;
               if (phase_ff == PH_CSTA && b == 8'h3F) priv_in = 1'b1;
               else if (b >= 8'h30 && b <= 8'h39) begin
                  if (pidx_ff == 3'd0 && sidx_ff == 2'd0) kc_in = add_digit(kc_ff, b[3:0]);
                  else if (pidx_ff == 3'd1 && sidx_ff == 2'd0)
                     md_in = add_digit(md_ff, b[3:0]);
                  else if (pidx_ff == 3'd1 && sidx_ff == 2'd1)
                     et_in = add_digit(et_ff, b[3:0]);
               end else if (b == 8'h3B) begin
                  if (pidx_ff < 3'd7) pidx_in = pidx_ff + 3'd1;
                  sidx_in = 2'd0;
               end else if (b == 8'h3A) begin
                  if (sidx_ff < 2'd3) sidx_in = sidx_ff + 2'd1;
               end else if (b >= 8'h40 && b <= 8'h7E) begin
                  phase_in = PH_IDLE;
                  if (!priv_ff) begin
                     if (b == 8'h49) begin
                        dfocus = 1'b1; dkind = tksd_pkg::KIND_FOCUS_IN;
                     end else if (b == 8'h4F) begin
                        dfocus = 1'b1; dkind = tksd_pkg::KIND_FOCUS_OUT; dclear = 1'b1;
                     end else if (ckey != tksd_pkg::NO_KEY) begin
                        dk[0] = ckey; dt[0] = ctype; dn = 2'd1;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (b == 8'h1B) begin
                  phase_in = PH_ESC; since_in = item_ff.now_ms;
               end else if (plain_key(b) != tksd_pkg::NO_KEY) begin
                  dk[0] = plain_key(b); dn = 2'd1;
               end
            end
         endcase
      end
   end

   // Timeout check runs after decode, on the updated parser state.
   logic [31:0] age;
   logic        tmo;
   assign age = item_ff.now_ms - since_ff;
   assign tmo = (phase_ff != PH_IDLE) && (age >= {16'd0, esc_alone_ff});

   // Shared slot compare and repeat arithmetic.
   logic [8:0]  cur_key;
   logic [1:0]  cur_type;
   logic [SLOT_CNT_W-1:0] hit;
   logic [31:0] dms;
   logic [16:0] hold_sum;
   logic        rep;
   assign cur_key  = pk_key_ff[pcur_ff];
   assign cur_type = pk_type_ff[pcur_ff];
   assign hit = found_ff ? fidx_ff : (hasfree_ff ? freeidx_ff : '0);
   assign dms = item_ff.now_ms - (found_ff ? slot_ms_ff[hit] : 32'd0);
   assign hold_sum = {1'b0, hold_first_ff} + {1'b0, hold_repeat_ff};
   assign rep = (cur_type == tksd_pkg::TYPE_REPEAT) ||
                (!kitty_ff && found_ff && slot_down_ff[hit] && dms < {15'd0, hold_sum});

   always_ff @(posedge clock) begin
      if (reset) begin
         kitty_ff <= 1'b0; esc_alone_ff <= 16'd50;
         hold_first_ff <= 16'd500; hold_repeat_ff <= 16'd100;
         phase_ff <= PH_IDLE; priv_ff <= 1'b0; pidx_ff <= 3'd0; sidx_ff <= 2'd0;
         kc_ff <= 17'd0; md_ff <= 17'd0; et_ff <= 17'd0; since_ff <= 32'd0;
         for (int i = 0; i < tksd_pkg::KEY_SLOTS; i++) begin
            slot_key_ff[i] <= 9'd0; slot_down_ff[i] <= 1'b0; slot_ms_ff[i] <= 32'd0;
         end
         st_ff <= ST_IDLE; ocnt_ff <= 2'd0; orp_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
               tksd_pkg::REG_KITTY:      kitty_ff <= pwdata[0];
               tksd_pkg::REG_ESC_ALONE:  esc_alone_ff <= pwdata[15:0];
               tksd_pkg::REG_HOLD_FIRST: hold_first_ff <= pwdata[15:0];
               default:                  hold_repeat_ff <= pwdata[15:0];
            endcase
         end
         unique case (st_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff <= req_data; st_ff <= ST_DECODE;
                  ocnt_ff <= 2'd0; orp_ff <= 1'b0;
               end
            end
            ST_DECODE: begin
               phase_ff <= phase_in; priv_ff <= priv_in; pidx_ff <= pidx_in;
               sidx_ff <= sidx_in; kc_ff <= kc_in; md_ff <= md_in; et_ff <= et_in;
               since_ff <= since_in;
               pk_key_ff[0] <= dk[0]; pk_key_ff[1] <= dk[1];
               pk_type_ff[0] <= dt[0]; pk_type_ff[1] <= dt[1];
               npress_ff <= dn; pcur_ff <= 1'b0;
               if (dfocus) begin
                  obuf_ff[0] <= '{event_kind: dkind, key: 9'd0, repeat_res: 1'b0, last: 1'b0};
                  ocnt_ff <= 2'd1;
                  if (dclear) begin
                     for (int i = 0; i < tksd_pkg::KEY_SLOTS; i++) begin
                        slot_key_ff[i] <= 9'd0; slot_down_ff[i] <= 1'b0;
                        slot_ms_ff[i] <= 32'd0;
                     end
                  end
               end
               scan_ff <= '0; found_ff <= 1'b0; hasfree_ff <= 1'b0;
               st_ff <= (dn != 2'd0) ? ST_SCAN : ST_FLUSH;
            end
            ST_SCAN: begin
               // One slot compared per cycle; first match wins, first free remembered.
               if (!found_ff) begin
                  if (slot_key_ff[scan_ff] == cur_key) begin
                     found_ff <= 1'b1; fidx_ff <= scan_ff;
                  end else if (!hasfree_ff && slot_key_ff[scan_ff] == 9'd0) begin
                     hasfree_ff <= 1'b1; freeidx_ff <= scan_ff;
                  end
               end
               if (scan_ff == SLOT_LAST) st_ff <= ST_APPLY;
               else scan_ff <= scan_ff + 1'b1;
            end
            ST_APPLY: begin
               if (cur_type == tksd_pkg::TYPE_RELEASE) begin
                  slot_key_ff[hit] <= 9'd0; slot_down_ff[hit] <= 1'b0;
                  if (!found_ff) slot_ms_ff[hit] <= 32'd0;
               end else begin
                  slot_key_ff[hit] <= cur_key; slot_down_ff[hit] <= 1'b1;
                  slot_ms_ff[hit] <= item_ff.now_ms;
                  obuf_ff[ocnt_ff[0]] <= '{event_kind: tksd_pkg::KIND_PRESS, key: cur_key,
                                            repeat_res: rep, last: 1'b0};
                  ocnt_ff <= ocnt_ff + 2'd1;
               end
               scan_ff <= '0; found_ff <= 1'b0; hasfree_ff <= 1'b0;
               if (!pcur_ff && npress_ff == 2'd2) begin
                  pcur_ff <= 1'b1; st_ff <= ST_SCAN;
               end else st_ff <= ST_FLUSH;
            end
            ST_FLUSH: begin
               if (tmo) begin
                  phase_ff <= PH_IDLE;
                  if (phase_ff == PH_ESC || phase_ff == PH_SS3) begin
                     pk_key_ff[0] <= (phase_ff == PH_ESC) ? tksd_pkg::KEY_ESC
                                                         : tksd_pkg::KEY_LOWER_O;
                     pk_type_ff[0] <= tksd_pkg::TYPE_PRESS;
                     npress_ff <= 2'd1; pcur_ff <= 1'b0;
                     st_ff <= ST_SCAN;
                  end else st_ff <= (ocnt_ff != 2'd0) ? ST_OUT : ST_IDLE;
               end else st_ff <= (ocnt_ff != 2'd0) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  if (orp_ff || ocnt_ff == 2'd1) st_ff <= ST_IDLE;
                  orp_ff <= 1'b1;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // Results are sent from the buffer once the whole transfer is decoded.
   logic [1:0] last_idx;
   assign last_idx = ocnt_ff - 2'd1;
   assign rsp_valid = (st_ff == ST_OUT);
   always_comb begin
      rsp_data = obuf_ff[orp_ff];
      rsp_data.last = ({1'b0, orp_ff} == last_idx);
   end

endmodule

// ----- rtl/tksd_checker.sv -----
// Port-level checker for the terminal key sequence decoder, bound to the top level.
module tksd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tksd_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while results pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block ready right after a transfer");

   a_focus_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_kind != tksd_pkg::KIND_PRESS |->
      rsp_data.key == 9'd0 && !rsp_data.repeat_res)
      else $error("focus event carries key data");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

// ----- bench/tb_terminal_key_sequence_decoder.sv -----
// Self-checking testbench for the terminal key sequence decoder.
module tb_terminal_key_sequence_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PH_IDLE = 0, PH_ESC = 1, PH_SS3 = 2, PH_CSI_START = 3, PH_CSI_BODY = 4;

   // Keeps a software copy of the decoder state and the queue of expected key events.
   class key_event_scoreboard;
      bit        kitty;
      bit [15:0] esc_alone, hold_first, hold_repeat;
      int        phase;
      bit        priv;
      bit [2:0]  pidx;
      bit [1:0]  sidx;
      bit [16:0] code_p, mod_p, type_p;
      bit [31:0] pend_since;
      bit [8:0]  skey[tksd_pkg::KEY_SLOTS];
      bit        sdown[tksd_pkg::KEY_SLOTS];
      bit [31:0] slast[tksd_pkg::KEY_SLOTS];
      tksd_pkg::rsp_type pending_events[$];
      tksd_pkg::rsp_type step_out[$];
      int        mismatches, checked, presses, repeats, focus;

      function new();
         kitty = 0; esc_alone = 50; hold_first = 500; hold_repeat = 100;
         phase = PH_IDLE; priv = 0; pidx = 0; sidx = 0;
         code_p = 0; mod_p = 0; type_p = 0; pend_since = 0;
         foreach (skey[i]) begin
            skey[i] = 0; sdown[i] = 0; slast[i] = 0;
         end
      endfunction

      function void set_reg(logic [1:0] idx, bit [31:0] v);
         case (idx)
            tksd_pkg::REG_KITTY:       kitty = v[0];
            tksd_pkg::REG_ESC_ALONE:   esc_alone = v[15:0];
            tksd_pkg::REG_HOLD_FIRST:  hold_first = v[15:0];
            tksd_pkg::REG_HOLD_REPEAT: hold_repeat = v[15:0];
         endcase
      endfunction

      function void add_event(logic [1:0] kind, logic [8:0] k, bit rep);
         tksd_pkg::rsp_type r;
         r.event_kind = kind; r.key = k; r.repeat_res = rep; r.last = 0;
         step_out.push_back(r);
      endfunction

      function void key_press(bit [8:0] k, int etype, bit [31:0] now);
         int idx, fr;
         bit rep;
         bit [32:0] lim;
         idx = -1; fr = -1;
         for (int i = 0; i < tksd_pkg::KEY_SLOTS; i++) begin
            if (skey[i] == k) begin
               idx = i;
               break;
            end
            if (fr < 0 && skey[i] == 0) fr = i;
         end
         if (idx < 0) begin
            idx = fr < 0 ? 0 : fr;
            skey[idx] = k; sdown[idx] = 0; slast[idx] = 0;
         end
         if (etype == 3) begin
            sdown[idx] = 0; skey[idx] = 0;
            return;
         end
         lim = hold_first + hold_repeat;
         rep = (etype == 2) || (!kitty && sdown[idx] && ({1'b0, now - slast[idx]} < lim));
         slast[idx] = now; sdown[idx] = 1;
         add_event(tksd_pkg::KIND_PRESS, k, rep);
      endfunction

      function void plain(bit [7:0] c, bit [31:0] now);
         bit [8:0] k;
         if (c == 3) k = tksd_pkg::CTRL_C_KEY;
         else if (c == 12) k = tksd_pkg::CTRL_L_KEY;
         else if (c == 13 || c == 10) k = tksd_pkg::ENTER_KEY;
         else if (c == 32) k = tksd_pkg::SPACE_KEY;
         else if (c >= "A" && c <= "Z") k = {1'b0, c} + 9'd32;
         else if (c >= 8'h80 || c < 32) return;
         else k = {1'b0, c};
         key_press(k, 1, now);
      endfunction

      function bit [16:0] digit(bit [16:0] p, int d);
         int v;
         v = p[16] ? int'(p[15:0]) : 0;
         v = v * 10 + d;
         if (v > 65535) v = 65535;
         return {1'b1, v[15:0]};
      endfunction

      function void csi_end(bit [7:0] f, bit [31:0] now);
         int mods, etype, code;
         bit [8:0] k;
         k = tksd_pkg::NO_KEY;
         if (priv) return;
         if (f == "I") begin
            add_event(tksd_pkg::KIND_FOCUS_IN, tksd_pkg::NO_KEY, 0);
            return;
         end
         if (f == "O") begin
            foreach (skey[i]) begin
               skey[i] = 0; sdown[i] = 0; slast[i] = 0;
            end
            add_event(tksd_pkg::KIND_FOCUS_OUT, tksd_pkg::NO_KEY, 0);
            return;
         end
         mods = (mod_p[16] && mod_p[15:0] >= 1) ? int'(mod_p[15:0]) - 1 : 0;
         etype = (type_p[16] && type_p[15:0] >= 1) ? int'(type_p[15:0]) : 1;
         code = int'(code_p[15:0]);
         if (f == "A") k = tksd_pkg::KEY_UP;
         else if (f == "B") k = tksd_pkg::DOWN_ARROW;
         else if (f == "C") k = tksd_pkg::RIGHT_ARROW;
         else if (f == "D") k = tksd_pkg::LEFT_ARROW;
         else if (f == "u" && code_p[16]) begin
            if (code == 27) k = tksd_pkg::KEY_ESC;
            else if (code == 13) k = tksd_pkg::ENTER_KEY;
            else if (code == 32) k = tksd_pkg::SPACE_KEY;
            else if (code == "c" && mods[2]) k = tksd_pkg::CTRL_C_KEY;
            else if (code == "l" && mods[2]) k = tksd_pkg::CTRL_L_KEY;
            else if (code >= "A" && code <= "Z") k = 9'(code + 32);
            else if (code > 32 && code < 127) k = 9'(code);
         end
         if (k != tksd_pkg::NO_KEY) key_press(k, etype, now);
      endfunction

      function void csi_byte(bit [7:0] b, bit [31:0] now);
         if (b >= "0" && b <= "9") begin
            if (pidx == 0 && sidx == 0) code_p = digit(code_p, b - "0");
            else if (pidx == 1 && sidx == 0) mod_p = digit(mod_p, b - "0");
            else if (pidx == 1 && sidx == 1) type_p = digit(type_p, b - "0");
         end else if (b == ";") begin
            if (pidx < 7) pidx++;
            sidx = 0;
         end else if (b == ":") begin
            if (sidx < 3) sidx++;
         end else if (b >= 8'h40 && b <= 8'h7e) begin
            phase = PH_IDLE;
            csi_end(b, now);
         end
      endfunction

      function void note_request(tksd_pkg::req_type q);
         bit [7:0] b;
         bit [31:0] now;
         b = q.data_byte; now = q.now_ms;
         step_out.delete();
         if (!q.func) begin
            case (phase)
               PH_ESC: begin
                  if (b == "O") phase = PH_SS3;
                  else if (b == "[") begin
                     phase = PH_CSI_START; priv = 0; pidx = 0; sidx = 0;
                     code_p = 0; mod_p = 0; type_p = 0;
                  end else begin
                     key_press(tksd_pkg::KEY_ESC, 1, now);
                     phase = PH_IDLE;
                     if (b == 8'h1b) begin
                        phase = PH_ESC; pend_since = now;
                     end else plain(b, now);
                  end
               end
               PH_SS3: begin
                  phase = PH_IDLE;
                  if (b == "A") key_press(tksd_pkg::KEY_UP, 1, now);
                  else if (b == "B") key_press(tksd_pkg::DOWN_ARROW, 1, now);
                  else if (b == "C") key_press(tksd_pkg::RIGHT_ARROW, 1, now);
                  else if (b == "D") key_press(tksd_pkg::LEFT_ARROW, 1, now);
               end
               PH_CSI_START: begin
                  phase = PH_CSI_BODY;
                  if (b == "?") priv = 1;
                  else csi_byte(b, now);
               end
               PH_CSI_BODY: csi_byte(b, now);
               default: begin
                  phase = PH_IDLE;
                  if (b == 8'h1b) begin
                     phase = PH_ESC; pend_since = now;
                  end else plain(b, now);
               end
            endcase
         end
         if (phase != PH_IDLE && (now - pend_since) >= {16'd0, esc_alone}) begin
            if (phase == PH_ESC) key_press(tksd_pkg::KEY_ESC, 1, now);
            else if (phase == PH_SS3) key_press(tksd_pkg::KEY_LOWER_O, 1, now);
            phase = PH_IDLE;
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
         foreach (step_out[i]) begin
            if (step_out[i].event_kind != tksd_pkg::KIND_PRESS) focus++;
            else if (step_out[i].repeat_res) repeats++;
            else presses++;
            pending_events.push_back(step_out[i]);
         end
      endfunction

      function void check_result(tksd_pkg::rsp_type got);
         tksd_pkg::rsp_type w;
         checked++;
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected nothing, got %p", got);
            return;
         end
         w = pending_events.pop_front();
         if (got.event_kind !== w.event_kind || got.key !== w.key ||
             got.repeat_res !== w.repeat_res || got.last !== w.last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", w, got);
         end
      endfunction
   endclass

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   tksd_pkg::req_type req_data = '0;
   tksd_pkg::rsp_type rsp_data;
   logic        psel = 0, penable = 0, pwrite = 0, pready;
   logic [3:0]  paddr = 0;
   logic [31:0] pwdata = 0, prdata;

   terminal_key_sequence_decoder u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   key_event_scoreboard board = new();
   int        send_idle = 27, recv_idle = 51, hold_off = 0;
   bit        hold_request = 0, hold_done = 0;
   bit [31:0] clock_ms = 1000;
   int        sent = 0;

   // The receiver stalls at random; a long hold-off forces the block to back up.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      if (hold_request && !hold_done) begin
         hold_done <= 1;
         hold_off <= 400;
         rsp_stall <= 1;
      end else if (hold_off > 0) begin
         rsp_stall <= 1;
         hold_off <= hold_off - 1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic write_reg(logic [1:0] idx, bit [31:0] v);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      board.set_reg(idx, v);
      @(posedge clock);
   endtask

   // Valid stays high after a transfer until an idle cycle or a drain lowers it; a new request only replaces its data.
   task automatic send_req(bit fn, bit [7:0] b, bit [31:0] now);
      tksd_pkg::req_type q;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      q.func = fn; q.data_byte = b; q.now_ms = now;
      req_valid <= 1; req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(q);
      sent++;
   endtask

   task automatic send_byte(bit [7:0] b);
      clock_ms += $urandom_range(3);
      send_req(0, b, clock_ms);
   endtask

   task automatic send_str(string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (board.pending_events.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   // Picks a random key sequence, mostly well formed.
   task automatic random_seq();
      int sel;
      string s;
      sel = $urandom_range(99);
      clock_ms += ($urandom_range(9) == 0) ? $urandom_range(2000) : $urandom_range(120);
      if (sel < 30)
         send_byte($urandom_range(9) < 7 ? 8'("a" + $urandom_range(4)) : 8'($urandom));
      else if (sel < 40) begin
         send_byte(8'h1b); send_byte("O"); send_byte(8'("A" + $urandom_range(4)));
      end else if (sel < 75) begin
         s = $sformatf("\033[%0d", $urandom_range(9) == 0 ? $urandom : 97 + $urandom_range(3));
         if ($urandom_range(2) != 0) s = {s, $sformatf(";%0d", 1 + $urandom_range(8))};
         if ($urandom_range(1)) s = {s, $sformatf(":%0d", $urandom_range(4))};
         send_str(s);
         send_byte($urandom_range(5) == 0 ? 8'("A" + $urandom_range(3)) : "u");
      end else if (sel < 82) begin
         send_byte(8'h1b);
         if ($urandom_range(1)) send_byte("[");
         if ($urandom_range(1)) send_byte(8'h1b);
         clock_ms += $urandom_range(100);
         send_req(1, 8'($urandom), clock_ms);
      end else if (sel < 88) send_str($urandom_range(1) ? "\033[I" : "\033[O");
      else if (sel < 92) send_str("\033[?1u");
      else if (sel < 96) begin
         clock_ms += $urandom_range(80);
         send_req(1, 8'($urandom), clock_ms);
      end else send_req(1'($urandom_range(1)), 8'($urandom), $urandom);
   endtask

   initial begin
      #50ms;
      $display("tb_terminal_key_sequence_decoder: done, errors");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: plain bytes, arrows, kitty codes, focus, timeouts and saturation.
      send_byte(8'd3); send_byte(8'd12); send_byte(8'd10); send_byte("Z");
      send_byte(8'hff); send_byte(8'd0); send_byte(8'h7f);
      send_str("\033OA"); send_str("\033x"); send_str("\033\033");
      send_str("\033[99;5u"); send_str("\033[108;5:2u"); send_str("\033[99999999u");
      send_str("\033[65;1:3u"); send_str("\033[I"); send_str("\033[O");
      send_str("\033[?u"); send_str("\033[1;;;;;;;;::::B");
      send_byte(8'h1b); clock_ms += 60; send_req(1, 0, clock_ms);
      send_str("\033O"); clock_ms += 60; send_req(1, 0, clock_ms);
      send_req(1, 8'h00, 32'hffff_ffff); send_req(0, 8'hff, 32'h0);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 0) begin
            send_idle = 27; recv_idle = 51;
         end else if (ph == 2) begin
            send_idle = 51; recv_idle = 27;
         end else if (ph == 4) begin
            send_idle = 0; recv_idle = 0;
         end
         write_reg(tksd_pkg::REG_KITTY, ph % 2);
         write_reg(tksd_pkg::REG_ESC_ALONE,
                   ph == 3 ? 0 : ph == 5 ? 65535 : 20 + $urandom_range(60));
         write_reg(tksd_pkg::REG_HOLD_FIRST,
                   ph == 1 ? 65535 : ph == 2 ? 0 : $urandom_range(600));
         write_reg(tksd_pkg::REG_HOLD_REPEAT,
                   ph == 1 ? 65535 : ph == 2 ? 0 : $urandom_range(150));
         if (ph == 4) hold_request = 1;
         repeat (70) random_seq();
         drain();
      end
      $display("covered %0d transfers in: %0d presses, %0d repeats, %0d focus events",
               sent, board.presses, board.repeats, board.focus);
      $display("kitty and legacy modes, timeout extremes and three idling patterns");
      if (board.mismatches == 0 && board.pending_events.size() == 0)
         $display("tb_terminal_key_sequence_decoder: done, clean");
      else
         $display("tb_terminal_key_sequence_decoder: done, errors");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/tksd_pkg.sv
rtl/terminal_key_sequence_decoder.sv
rtl/tksd_checker.sv
bench/tb_terminal_key_sequence_decoder.sv
